// ===== sv/assembly_source_tokenizer_unit_defines.svh =====
// Assertion macros shared by the tokenizer RTL files.
`ifndef ASSEMBLY_SOURCE_TOKENIZER_UNIT_DEFINES_SVH
`define ASSEMBLY_SOURCE_TOKENIZER_UNIT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASTOK_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASTOK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/astok_pkg.sv =====
// Types, codes and constants of the assembly source tokenizer.
package astok_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned KIND_W      = 4;
  localparam int unsigned ERR_W       = 4;
  localparam int unsigned LINE_W      = 23;
  localparam int unsigned MAX_BYTES_W = 23;

  localparam int unsigned DEFAULT_COUNT_WIDTH = 23;
  localparam int unsigned DEFAULT_QUEUE_DEPTH = 4;

  localparam logic [MAX_BYTES_W-1:0] MAX_BYTES_RESET = 23'h400000;

  // Characters the lexer decodes.
  localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_VTAB    = 8'h0b;
  localparam logic [BYTE_W-1:0] CH_FFEED   = 8'h0c;
  localparam logic [BYTE_W-1:0] CH_CRET    = 8'h0d;
  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] CH_QUOTE   = 8'h22;
  localparam logic [BYTE_W-1:0] CH_HASH    = 8'h23;
  localparam logic [BYTE_W-1:0] CH_LPAREN  = 8'h28;
  localparam logic [BYTE_W-1:0] CH_RPAREN  = 8'h29;
  localparam logic [BYTE_W-1:0] CH_COMMA   = 8'h2c;
  localparam logic [BYTE_W-1:0] CH_EQUALS  = 8'h3d;
  localparam logic [BYTE_W-1:0] CH_TILDE   = 8'h7e;

  typedef enum logic [KIND_W-1:0] {
    TK_WORD_BYTE = 4'd0,
    TK_WORD_END  = 4'd1,
    TK_QUOTE     = 4'd2,
    TK_OPEN      = 4'd3,
    TK_CLOSE     = 4'd4,
    TK_COMMA     = 4'd5,
    TK_EQUALS    = 4'd6,
    TK_EOL       = 4'd7,
    TK_ERROR     = 4'd8
  } token_kind_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE         = 4'd0,
    ERR_TOO_LARGE    = 4'd1,
    ERR_SPANS_LINE   = 4'd2,
    ERR_BAD_STR_CHAR = 4'd3,
    ERR_BAD_CHAR     = 4'd4,
    ERR_NESTED       = 4'd5,
    ERR_UNMATCHED    = 4'd6,
    ERR_READ_FAIL    = 4'd7,
    ERR_UNTERMINATED = 4'd8
  } err_code_e;

  // One queue entry holds every word caused by one input item. All words of
  // an item share its line; only the first word can carry a char or a code.
  typedef struct packed {
    logic [LINE_W-1:0] line;
    token_kind_e       kind0;
    logic [BYTE_W-1:0] char0;
    err_code_e         err0;
    logic              two;
    token_kind_e       kind1;
  } queue_entry_t;

endpackage

// ===== sv/astok_if.sv =====
// Handshake interfaces for the source byte channel and the token channel.
interface astok_in_if;
  import astok_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] source_byte;
  logic              end_of_input;
  logic              read_failed;

  modport source (output valid, source_byte, end_of_input, read_failed, input ready);
  modport sink   (input valid, source_byte, end_of_input, read_failed, output ready);
endinterface

interface astok_tok_if;
  import astok_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] token_kind;
  logic [LINE_W-1:0] line_number;
  logic [BYTE_W-1:0] char_value;
  logic [ERR_W-1:0]  error_code;
  logic              last_of_item;

  modport source (output valid, token_kind, line_number, char_value, error_code,
                  last_of_item, input ready);
  modport sink   (input valid, token_kind, line_number, char_value, error_code,
                  last_of_item, output ready);
endinterface

// ===== sv/astok_fifo.sv =====
// Short queue of classified items between the lexer front and the emit back.
`include "assembly_source_tokenizer_unit_defines.svh"

module astok_fifo #(
  parameter int unsigned QUEUE_DEPTH = astok_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  astok_pkg::queue_entry_t entry_i,
  input  logic                   pop_i,
  output astok_pkg::queue_entry_t head_o,
  output logic                   full_o,
  output logic                   empty_o
);
  import astok_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  queue_entry_t     mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Pointers wrap at the depth, so any depth works.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  `ASTOK_ASSERT_IMPL(a_fifo_no_overflow, push_i, !full_o, "push into a full queue")
endmodule

// ===== sv/astok_front.sv =====
// Lexer front: accepts source bytes, keeps the lexer state and classifies tokens.
`include "assembly_source_tokenizer_unit_defines.svh"

module astok_front #(
  parameter int unsigned COUNT_WIDTH = astok_pkg::DEFAULT_COUNT_WIDTH
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  astok_in_if.sink                              byte_i,
  input  logic                                  cfg_we_i,
  input  logic [astok_pkg::MAX_BYTES_W-1:0]     cfg_wdata_i,
  input  logic                                  full_i,
  output logic                                  push_o,
  output astok_pkg::queue_entry_t               entry_o
);
  import astok_pkg::*;

  localparam int unsigned CMP_W  = (COUNT_WIDTH + 1 > MAX_BYTES_W) ? COUNT_WIDTH + 1
                                                                   : MAX_BYTES_W;
  localparam int unsigned LEXT_W = (COUNT_WIDTH > LINE_W) ? COUNT_WIDTH : LINE_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic [MAX_BYTES_W-1:0] max_bytes_q;
  logic                   in_string_q, in_string_d;
  logic                   in_paren_q, in_paren_d;
  logic                   in_comment_q, in_comment_d;
  logic                   line_tok_q, line_tok_d;
  logic                   word_pend_q, word_pend_d;
  logic                   halted_q, halted_d;
  logic [COUNT_WIDTH-1:0] line_q, line_d;
  logic [COUNT_WIDTH-1:0] bytes_q, bytes_d;

  logic                   accept;
  logic [BYTE_W-1:0]      ch;
  logic                   printable;
  logic                   too_large;
  logic [LEXT_W-1:0]      line_ext;

  logic                   tok_a_v;
  token_kind_e            tok_a_kind;
  logic [BYTE_W-1:0]      tok_a_char;
  logic                   tok_b_v;
  token_kind_e            tok_b_kind;
  logic                   fail;
  err_code_e              fail_code;
  logic                   err_push;

  assign byte_i.ready = !full_i;
  assign accept       = byte_i.valid && !full_i;
  assign ch           = byte_i.source_byte;
  assign printable    = (ch >= CH_SPACE) && (ch <= CH_TILDE);
  assign too_large    = (CMP_W'(bytes_q) + 1'b1) > CMP_W'(max_bytes_q);
  assign line_ext     = LEXT_W'(line_q);

  // Lexer step: at most two tokens per item, first one may be a word byte.
  always_comb begin
    in_string_d  = in_string_q;
    in_paren_d   = in_paren_q;
    in_comment_d = in_comment_q;
    line_tok_d   = line_tok_q;
    word_pend_d  = word_pend_q;
    halted_d     = halted_q;
    line_d       = line_q;
    bytes_d      = bytes_q;
    tok_a_v      = 1'b0;
    tok_a_kind   = TK_WORD_END;
    tok_a_char   = '0;
    tok_b_v      = 1'b0;
    tok_b_kind   = TK_EOL;
    fail         = 1'b0;
    fail_code    = ERR_NONE;

    if (accept && !halted_q) begin
      if (byte_i.end_of_input) begin
        if (byte_i.read_failed) begin
          fail      = 1'b1;
          fail_code = ERR_READ_FAIL;
        end else if (in_string_q || in_paren_q) begin
          fail      = 1'b1;
          fail_code = ERR_UNTERMINATED;
        end else begin
          // Close a pending word, then end the line if it held a token.
          tok_a_v     = word_pend_q;
          tok_b_v     = line_tok_q || word_pend_q;
          word_pend_d = 1'b0;
          line_tok_d  = 1'b0;
          halted_d    = 1'b1;
        end
      end else if (too_large) begin
        fail      = 1'b1;
        fail_code = ERR_TOO_LARGE;
      end else begin
        bytes_d = (bytes_q == CNT_MAX) ? bytes_q : bytes_q + 1'b1;
        if (ch == CH_NEWLINE) begin
          if (in_string_q || in_paren_q) begin
            fail      = 1'b1;
            fail_code = ERR_SPANS_LINE;
          end else begin
            tok_a_v      = word_pend_q;
            tok_b_v      = line_tok_q || word_pend_q;
            word_pend_d  = 1'b0;
            line_tok_d   = 1'b0;
            in_comment_d = 1'b0;
            line_d       = (line_q == CNT_MAX) ? line_q : line_q + 1'b1;
          end
        end else if (in_comment_q) begin
          // Comment text is dropped.
        end else if (in_string_q) begin
          if (ch == CH_QUOTE) begin
            // A closing quote always ends the literal's word, even when empty.
            tok_a_v     = 1'b1;
            tok_b_v     = 1'b1;
            tok_b_kind  = TK_QUOTE;
            in_string_d = 1'b0;
            line_tok_d  = 1'b1;
          end else if (!printable) begin
            fail      = 1'b1;
            fail_code = ERR_BAD_STR_CHAR;
          end else begin
            tok_a_v    = 1'b1;
            tok_a_kind = TK_WORD_BYTE;
            tok_a_char = ch;
          end
        end else begin
          // Most characters close a pending word first.
          tok_a_v = word_pend_q;
          unique case (ch) inside
            CH_HASH: begin
              in_comment_d = 1'b1;
              word_pend_d  = 1'b0;
              line_tok_d   = line_tok_q || word_pend_q;
            end
            CH_SPACE, CH_TAB, CH_CRET, CH_VTAB, CH_FFEED: begin
              word_pend_d = 1'b0;
              line_tok_d  = line_tok_q || word_pend_q;
            end
            CH_QUOTE: begin
              tok_b_v     = 1'b1;
              tok_b_kind  = TK_QUOTE;
              in_string_d = 1'b1;
              word_pend_d = 1'b0;
              line_tok_d  = 1'b1;
            end
            CH_LPAREN: begin
              if (in_paren_q) begin
                fail      = 1'b1;
                fail_code = ERR_NESTED;
              end else begin
                tok_b_v     = 1'b1;
                tok_b_kind  = TK_OPEN;
                in_paren_d  = 1'b1;
                word_pend_d = 1'b0;
                line_tok_d  = 1'b1;
              end
            end
            CH_RPAREN: begin
              if (!in_paren_q) begin
                fail      = 1'b1;
                fail_code = ERR_UNMATCHED;
              end else begin
                tok_b_v     = 1'b1;
                tok_b_kind  = TK_CLOSE;
                in_paren_d  = 1'b0;
                word_pend_d = 1'b0;
                line_tok_d  = 1'b1;
              end
            end
            CH_COMMA: begin
              tok_b_v     = 1'b1;
              tok_b_kind  = TK_COMMA;
              word_pend_d = 1'b0;
              line_tok_d  = 1'b1;
            end
            CH_EQUALS: begin
              tok_b_v     = 1'b1;
              tok_b_kind  = TK_EQUALS;
              word_pend_d = 1'b0;
              line_tok_d  = 1'b1;
            end
            default: begin
              if (!printable) begin
                fail      = 1'b1;
                fail_code = ERR_BAD_CHAR;
              end else begin
                // A word byte streams out without closing anything.
                tok_a_v     = 1'b1;
                tok_a_kind  = TK_WORD_BYTE;
                tok_a_char  = ch;
                word_pend_d = 1'b1;
              end
            end
          endcase
        end
      end

      // An error replaces all tokens with one error word and halts.
      if (fail) begin
        tok_a_v  = 1'b1;
        tok_b_v  = 1'b0;
        halted_d = 1'b1;
      end
    end
  end

  // Pack the tokens of this item into one queue entry.
  always_comb begin
    entry_o.line  = line_ext[LINE_W-1:0];
    entry_o.kind0 = fail ? TK_ERROR : (tok_a_v ? tok_a_kind : tok_b_kind);
    entry_o.char0 = tok_a_v ? tok_a_char : '0;
    entry_o.err0  = fail_code;
    entry_o.two   = tok_a_v && tok_b_v;
    entry_o.kind1 = tok_b_kind;
  end

  assign push_o   = tok_a_v || tok_b_v;
  assign err_push = push_o && (entry_o.kind0 == TK_ERROR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q  <= MAX_BYTES_RESET;
      in_string_q  <= 1'b0;
      in_paren_q   <= 1'b0;
      in_comment_q <= 1'b0;
      line_tok_q   <= 1'b0;
      word_pend_q  <= 1'b0;
      halted_q     <= 1'b0;
      line_q       <= COUNT_WIDTH'(1);
      bytes_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        max_bytes_q <= cfg_wdata_i;
      end
      in_string_q  <= in_string_d;
      in_paren_q   <= in_paren_d;
      in_comment_q <= in_comment_d;
      line_tok_q   <= line_tok_d;
      word_pend_q  <= word_pend_d;
      halted_q     <= halted_d;
      line_q       <= line_d;
      bytes_q      <= bytes_d;
    end
  end

  `ASTOK_ASSERT_IMPL(a_front_halt_quiet, halted_q, !push_o, "token pushed while halted")
  `ASTOK_ASSERT_NEXT(a_front_error_halts, err_push, halted_q, "error did not halt the lexer")
endmodule

// ===== sv/astok_back.sv =====
// Emit back: unpacks queue entries into one token word per handshake.
`include "assembly_source_tokenizer_unit_defines.svh"

module astok_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  astok_pkg::queue_entry_t head_i,
  input  logic                    empty_i,
  output logic                    pop_o,
  astok_tok_if.source             token_o
);
  import astok_pkg::*;

  logic phase_q, phase_d;
  logic out_hs;
  logic last_word;

  assign last_word = phase_q || !head_i.two;
  assign out_hs    = token_o.valid && token_o.ready;
  assign pop_o     = out_hs && last_word;

  // The second word of an entry never carries a char or an error code.
  assign token_o.valid        = !empty_i;
  assign token_o.token_kind   = phase_q ? head_i.kind1 : head_i.kind0;
  assign token_o.line_number  = head_i.line;
  assign token_o.char_value   = phase_q ? '0 : head_i.char0;
  assign token_o.error_code   = phase_q ? ERR_NONE : head_i.err0;
  assign token_o.last_of_item = last_word;

  always_comb begin
    phase_d = phase_q;
    if (out_hs) begin
      phase_d = !last_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
    end
  end

  `ASTOK_ASSERT_IMPL(a_back_phase_valid, phase_q, !empty_i && head_i.two, "lone second word")
endmodule

// ===== sv/assembly_source_tokenizer_unit.sv =====
// Assembly source tokenizer: a streaming lexer for assembly source text.
//
// byte_i takes one word per item: a source byte, or an end-of-input marker
// with a read-failure flag. token_o gives token words tagged with their
// line number; last_of_item marks the final word caused by an item.
// cfg_we_i/cfg_wdata_i write the source size limit; write it only while idle.
// Throughput: one item per cycle when each item gives at most one word and
// the receiver is ready. An item that gives two words holds the token port
// until both are taken, so the port sets the rate at one word per cycle.
// A word reaches the token port only once its item is in the queue.
// A queue of default depth four parts the lexer front from the token port:
// when the receiver stalls, byte_i keeps accepting until the queue fills.
// Reset clears the lexer state, sets the line to one and the size limit to
// 4194304. An error gives one error word and halts the lexer until reset;
// an end-of-input item halts it as well. Halted items are taken and dropped.
module assembly_source_tokenizer_unit #(
  parameter int unsigned COUNT_WIDTH = astok_pkg::DEFAULT_COUNT_WIDTH,
  parameter int unsigned QUEUE_DEPTH = astok_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  astok_in_if.sink                          byte_i,
  astok_tok_if.source                       token_o,
  input  logic                              cfg_we_i,
  input  logic [astok_pkg::MAX_BYTES_W-1:0] cfg_wdata_i
);
  import astok_pkg::*;

  queue_entry_t push_entry;
  queue_entry_t head_entry;
  logic         push;
  logic         pop;
  logic         full;
  logic         empty;

  // Front: accept and classify source bytes.
  astok_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_i      (byte_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .full_i      (full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  // Queue between the two halves.
  astok_fifo #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head_entry),
    .full_o  (full),
    .empty_o (empty)
  );

  // Back: emit token words.
  astok_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head_entry),
    .empty_i (empty),
    .pop_o   (pop),
    .token_o (token_o)
  );
endmodule
